// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the second-chance replacer.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/scpr_pkg.sv -----
// Package for the second-chance page replacer: operation and status codes,
// the ring entry type and default sizes. No dependencies.
package scpr_pkg;

  localparam int SCPR_NUM_FRAMES = 16;
  localparam int FRAME_IDS       = 16;

  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_REFERENCE = 2'd1;
  localparam logic [1:0] OP_REPLACE   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] page;
    logic [3:0]  frame;
  } scpr_entry_t;

endpackage

// ----- rtl/scpr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the new data. No dependencies.
module scpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/second_chance_page_replacer_core.sv -----
// Second-chance page replacer. Insert and reference register their result in
// the cycle after acceptance. Replace issues the head read at acceptance and
// then examines entries, at most the entry count plus one, as the ring RAM
// reads and rewrites one entry per cycle. The input is not ready during a
// scan or while a result is held by a low out_ready. The ring RAM needs no
// clearing after reset. Uses scpr_pkg, scpr_ram and assert_macros.svh.
`include "assert_macros.svh"

module second_chance_page_replacer_core
  import scpr_pkg::*;
#(
  parameter int NUM_FRAMES = SCPR_NUM_FRAMES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_proc_id,
  input  logic [15:0] in_page_num,
  input  logic [3:0]  in_frame_num,
  input  logic        in_ref_init,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_victim_pid,
  output logic [15:0] out_victim_page,
  output logic [3:0]  out_victim_frame
);

  localparam int PTR_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int ENT_W = $bits(scpr_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [FRAME_IDS-1:0]   ref_bits_r, ref_bits_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  scpr_entry_t            out_entry_r, out_entry_nxt;

  logic [SUM_W-1:0]       tail_sum;
  logic [PTR_W-1:0]       tail;
  logic [PTR_W-1:0]       head_inc;
  scpr_entry_t            in_entry;
  scpr_entry_t            scan_entry;
  logic                   ref_hit;
  logic                   in_fire;

  logic                   ram_we;
  logic [PTR_W-1:0]       ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic [PTR_W-1:0]       ram_raddr;
  logic [ENT_W-1:0]       ram_rdata;

  scpr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_FRAMES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_victim_pid   = out_entry_r.pid;
  assign out_victim_page  = out_entry_r.page;
  assign out_victim_frame = out_entry_r.frame;

  always_comb begin
    in_entry.pid   = in_proc_id;
    in_entry.page  = in_page_num;
    in_entry.frame = in_frame_num;
    scan_entry     = scpr_entry_t'(ram_rdata);
    ref_hit        = ref_bits_r[scan_entry.frame];
    tail_sum       = SUM_W'(head_r) + SUM_W'(cnt_r);
    if (tail_sum >= SUM_W'(NUM_FRAMES)) begin
      tail = PTR_W'(tail_sum - SUM_W'(NUM_FRAMES));
    end else begin
      tail = PTR_W'(tail_sum);
    end
    if (head_r == PTR_W'(NUM_FRAMES - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    ref_bits_nxt   = ref_bits_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_wdata      = in_entry;
    ram_raddr      = head_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_entry_nxt  = '0;
          case (in_op)
            OP_INSERT: begin
              if (cnt_r == CNT_W'(NUM_FRAMES)) begin
                out_status_nxt = STATUS_FULL;
              end else begin
                ram_we                     = 1'b1;
                ref_bits_nxt[in_frame_num] = in_ref_init;
                cnt_nxt                    = cnt_r + 1'b1;
              end
            end
            OP_REFERENCE: begin
              ref_bits_nxt[in_frame_num] = 1'b1;
            end
            OP_REPLACE: begin
              if (cnt_r == '0) begin
                out_status_nxt = STATUS_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        head_nxt = head_inc;
        if (ref_hit) begin
          ref_bits_nxt[scan_entry.frame] = 1'b0;
          ram_we    = 1'b1;
          ram_wdata = scan_entry;
          ram_raddr = head_inc;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_entry_nxt  = scan_entry;
          cnt_nxt        = cnt_r - 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      ref_bits_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      ref_bits_r  <= ref_bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(NUM_FRAMES),
                 "Entry count exceeds the ring size.")
  `ASSERT_ALWAYS(a_head_bound, head_r <= PTR_W'(NUM_FRAMES - 1),
                 "Head pointer is out of range.")
  `ASSERT_IMPLIES(a_scan_nonempty, state_r == ST_SCAN, cnt_r != '0 && !out_valid_r,
                  "Scan runs on an empty ring or with a pending transaction.")
  `ASSERT_NEXT(a_victim_dec, state_r == ST_SCAN && !ref_hit,
               cnt_r + 1'b1 == $past(cnt_r) && out_valid_r,
               "Eviction did not remove exactly one entry.")

endmodule

// ----- test/scpr_victim_checker.sv -----
`timescale 1ns / 100ps
// Checker for the second-chance page replacer: watches both channels, predicts
// each result from its own copy of the ring and the reference bits, and compares.
// Depends on scpr_pkg for the operation and status codes and the entry type.
module scpr_victim_checker
  import scpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_proc_id,
  input  logic [15:0] in_page_num,
  input  logic [3:0]  in_frame_num,
  input  logic        in_ref_init,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_victim_pid,
  input  logic [15:0] out_victim_page,
  input  logic [3:0]  out_victim_frame,
  output int          fail_count,
  output int          pending_count
);

  localparam int SLOT_W = $clog2(SCPR_NUM_FRAMES);

  typedef struct packed {
    logic [1:0]  status;
    scpr_entry_t victim;
  } victim_result_t;

  scpr_entry_t    ring [SCPR_NUM_FRAMES];
  logic           ref_bit [FRAME_IDS];
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W:0]   occupancy;
  victim_result_t expected_victims [$];

  function automatic victim_result_t page_op_outcome(
    input logic [1:0]  op,
    input logic [7:0]  pid,
    input logic [15:0] page,
    input logic [3:0]  frame,
    input logic        rinit
  );
    victim_result_t res;
    int slot;
    res = '0;
    res.status = STATUS_OK;
    case (op)
      OP_INSERT: begin
        if (occupancy >= SCPR_NUM_FRAMES) begin
          res.status = STATUS_FULL;
        end else begin
          slot = (oldest + occupancy) % SCPR_NUM_FRAMES;
          ring[slot] = '{pid: pid, page: page, frame: frame};
          ref_bit[frame] = rinit;
          occupancy = occupancy + 1'b1;
        end
      end
      OP_REFERENCE: begin
        ref_bit[frame] = 1'b1;
      end
      OP_REPLACE: begin
        if (occupancy == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          slot = int'(oldest);
          while (ref_bit[ring[slot].frame]) begin
            ref_bit[ring[slot].frame] = 1'b0;
            ring[(slot + occupancy) % SCPR_NUM_FRAMES] = ring[slot];
            slot = (slot + 1) % SCPR_NUM_FRAMES;
          end
          res.victim = ring[slot];
          oldest = SLOT_W'((slot + 1) % SCPR_NUM_FRAMES);
          occupancy = occupancy - 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int field_mismatch(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    int errs;
    victim_result_t want;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < FRAME_IDS; i++) begin
        ref_bit[i] = 1'b0;
      end
      oldest = '0;
      occupancy = '0;
      expected_victims.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_victims.size() == 0) begin
          $error("out_status: result transaction with no expected value, actual %0d",
                 out_status);
          errs = errs + 1;
        end else begin
          want = expected_victims.pop_front();
          errs = errs + field_mismatch("status", 16'(want.status), 16'(out_status));
          errs = errs + field_mismatch("victim_pid", 16'(want.victim.pid),
                                       16'(out_victim_pid));
          errs = errs + field_mismatch("victim_page", want.victim.page, out_victim_page);
          errs = errs + field_mismatch("victim_frame", 16'(want.victim.frame),
                                       16'(out_victim_frame));
        end
      end
      if (in_valid && in_ready) begin
        expected_victims.push_back(page_op_outcome(in_op, in_proc_id, in_page_num,
                                                   in_frame_num, in_ref_init));
      end
    end
    if (errs != 0) begin
      fail_count <= fail_count + errs;
    end
    pending_count <= expected_victims.size();
  end

endmodule

// ----- test/second_chance_page_replacer_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the second-chance page replacer: clock, reset, directed and
// random page operations with random idling, a watchdog and the verdict.
// Depends on scpr_pkg, second_chance_page_replacer_core and scpr_victim_checker.
module second_chance_page_replacer_core_tb;
  import scpr_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RANDOM_OPS  = 2000;
  localparam int         CALM_TAIL   = 300;
  localparam int         STALL_LIMIT = 2000;
  localparam int         DRAIN_WAIT  = 24;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [7:0]  in_proc_id;
  logic [15:0] in_page_num;
  logic [3:0]  in_frame_num;
  logic        in_ref_init;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_victim_pid;
  logic [15:0] out_victim_page;
  logic [3:0]  out_victim_frame;
  logic        quiet;
  int          mismatches;
  int          outstanding;

  always #1 clk = ~clk;

  second_chance_page_replacer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_proc_id       (in_proc_id),
    .in_page_num      (in_page_num),
    .in_frame_num     (in_frame_num),
    .in_ref_init      (in_ref_init),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_victim_pid   (out_victim_pid),
    .out_victim_page  (out_victim_page),
    .out_victim_frame (out_victim_frame)
  );

  scpr_victim_checker victim_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_proc_id       (in_proc_id),
    .in_page_num      (in_page_num),
    .in_frame_num     (in_frame_num),
    .in_ref_init      (in_ref_init),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_victim_pid   (out_victim_pid),
    .out_victim_page  (out_victim_page),
    .out_victim_frame (out_victim_frame),
    .fail_count       (mismatches),
    .pending_count    (outstanding)
  );

  task automatic put_page_op(input logic [1:0] op, input logic [7:0] pid,
                             input logic [15:0] page, input logic [3:0] frame,
                             input logic rinit);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_proc_id   <= pid;
    in_page_num  <= page;
    in_frame_num <= frame;
    in_ref_init  <= rinit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int mode;
    int r;
    logic [1:0] op;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= OP_INSERT;
    in_proc_id   <= '0;
    in_page_num  <= '0;
    in_frame_num <= '0;
    in_ref_init  <= 1'b0;
    quiet        <= 1'b0;
    mode = 2;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_page_op(OP_REPLACE, 8'h00, 16'h0000, 4'h0, 1'b0);
    put_page_op(OP_UNUSED, 8'hFF, 16'hFFFF, 4'hF, 1'b1);
    put_page_op(OP_REFERENCE, 8'h00, 16'h0000, 4'h9, 1'b0);
    for (int i = 0; i < SCPR_NUM_FRAMES; i++) begin
      if (i == 0) begin
        put_page_op(OP_INSERT, 8'h00, 16'h0000, 4'h0, 1'b1);
      end else if (i == SCPR_NUM_FRAMES - 1) begin
        put_page_op(OP_INSERT, 8'hFF, 16'hFFFF, 4'(i), 1'b1);
      end else begin
        put_page_op(OP_INSERT, 8'($urandom), 16'($urandom), 4'(i), 1'b1);
      end
    end
    put_page_op(OP_INSERT, 8'hA5, 16'h5A5A, 4'h3, 1'b1);
    put_page_op(OP_REPLACE, 8'h00, 16'h0000, 4'h0, 1'b0);
    put_page_op(OP_REFERENCE, 8'h00, 16'h0000, 4'h1, 1'b0);
    put_page_op(OP_REPLACE, 8'h00, 16'h0000, 4'h0, 1'b0);
    put_page_op(OP_INSERT, 8'h3C, 16'h8001, 4'h4, 1'b0);
    put_page_op(OP_REPLACE, 8'h00, 16'h0000, 4'h0, 1'b0);
    wait_drained();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 64 == 0) begin
        mode = $urandom_range(0, 2);
        quiet <= (n >= RANDOM_OPS - CALM_TAIL) || ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_OPS - CALM_TAIL) begin
        quiet <= 1'b1;
      end
      if (n == RANDOM_OPS / 2) begin
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = OP_UNUSED;
      end else if (mode == 0) begin
        op = (r < 70) ? OP_INSERT : (r < 85) ? OP_REFERENCE : OP_REPLACE;
      end else if (mode == 1) begin
        op = (r < 18) ? OP_INSERT : (r < 35) ? OP_REFERENCE : OP_REPLACE;
      end else begin
        op = (r < 40) ? OP_INSERT : (r < 65) ? OP_REFERENCE : OP_REPLACE;
      end
      put_page_op(op, 8'($urandom), 16'($urandom), 4'($urandom), 1'($urandom));
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_sink
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle = idle + 1;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- second_chance_page_replacer_core.f -----
+incdir+rtl
rtl/scpr_pkg.sv
rtl/scpr_ram.sv
rtl/second_chance_page_replacer_core.sv
test/scpr_victim_checker.sv
test/second_chance_page_replacer_core_tb.sv
